>>> hdl/tick_alarm_slots_with_load_window_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tick alarm block
// Each macro expands to one labeled concurrent assertion on clk, disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_ALARM_SLOTS_WITH_LOAD_WINDOW_ASSERT_SVH
`define TICK_ALARM_SLOTS_WITH_LOAD_WINDOW_ASSERT_SVH

// Same-cycle implication.
`define TAS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TAS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg
// Types and constants of the tick alarm table with its busy-tick window.
// ----------------------------------------------------------------------------
package tas_pkg;

	// Default table size and window length.
	localparam int TAS_SLOTS        = 4;
	localparam int TAS_WINDOW_TICKS = 256;

	// Result field widths.
	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 2;
	localparam int BUSY_W  = 9;
	localparam int NOW_W   = 32;
	localparam int ARMED_W = 3;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_REPLY  = 2'd0,
		KIND_FIRE   = 2'd1,
		KIND_REPORT = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REG,
		ST_TICK,
		ST_SCAN,
		ST_REPORT,
		ST_FIRE,
		ST_DONE
	} state_t;

endpackage

>>> hdl/tick_alarm_slots_with_load_window.sv
// ----------------------------------------------------------------------------
// tick_alarm_slots_with_load_window
// Tick counter with a table of one-shot alarm slots and a busy-tick window.
//
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------
//  request   start / busy       mode, deadline, idle
//  result    strobe (1 cycle)   kind, slot, accepted, busy_ticks, now,
//                               armed_count, last
//
// A register request keeps busy high in the REG state; its reply shows the
// cycle after. A tick keeps busy high through TICK, SCAN of each slot, REPORT
// if due, FIRE per fired slot and DONE, set by the single deadline comparator
// that walks the slots one per cycle and by one result per cycle on the
// output. Results show in the cycle after the state that makes them; the
// receiver cannot stall. Reset clears the count, the window and every armed bit.
// ----------------------------------------------------------------------------
module tick_alarm_slots_with_load_window
	import tas_pkg::*;
#(
	parameter int SLOTS        = TAS_SLOTS,
	parameter int WINDOW_TICKS = TAS_WINDOW_TICKS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [NOW_W-1:0]    deadline,
	input  logic                idle,
	output logic                strobe,
	output logic [KIND_W-1:0]   kind,
	output logic [SLOT_W-1:0]   slot,
	output logic                accepted,
	output logic [BUSY_W-1:0]   busy_ticks,
	output logic [NOW_W-1:0]    now,
	output logic [ARMED_W-1:0]  armed_count,
	output logic                last
);

`include "tick_alarm_slots_with_load_window_assert.svh"

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int WIN_W   = $clog2(WINDOW_TICKS + 1);
	localparam int SEXT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int BEXT_W  = (WIN_W > BUSY_W) ? WIN_W : BUSY_W;
	localparam int AEXT_W  = (CNT_W > ARMED_W) ? CNT_W : ARMED_W;

	// Sequencer and request capture.
	state_t             state_q, state_nxt;
	logic [IDX_W-1:0]   idx_q;
	logic [NOW_W-1:0]   dl_in_q;
	logic               idle_q;

	// Block state.
	logic [NOW_W-1:0]   tick_q;
	logic [WIN_W-1:0]   win_ticks_q;
	logic [WIN_W-1:0]   win_busy_q;
	logic               report_q;
	logic [WIN_W-1:0]   report_busy_q;
	logic [SLOTS-1:0]   armed_q;
	logic [SLOTS-1:0]   fired_q;
	logic [CNT_W-1:0]   armed_cnt_q;
	logic [NOW_W-1:0]   dl_mem [SLOTS];

	// Result registers.
	logic               strobe_q;
	kind_t              kind_q;
	logic [IDX_W-1:0]   slot_q;
	logic               acc_q;
	logic [WIN_W-1:0]   busy_q;
	logic               last_q;

	// Next result values.
	logic               emit;
	kind_t              emit_kind;
	logic [IDX_W-1:0]   emit_slot;
	logic               emit_acc;
	logic [WIN_W-1:0]   emit_busy;
	logic               emit_last;

	logic               accept;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   fire_idx;
	logic               cmp_lt;
	logic               fire_hit;
	logic               scan_end;
	logic               fired_any_nxt;
	logic [SLOTS-1:0]   fired_rest;
	logic [WIN_W-1:0]   wt_inc;
	logic [WIN_W-1:0]   wb_inc;
	logic               win_full;
	logic [SEXT_W-1:0]  slot_ext;
	logic [BEXT_W-1:0]  busy_ext;
	logic [AEXT_W-1:0]  armed_ext;

	// Index of the lowest set bit, zero when none is set.
	function automatic logic [IDX_W-1:0] lowest_idx(input logic [SLOTS-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Slot selection: lowest free slot and lowest pending fire.
	assign free_found = |(~armed_q);
	assign free_idx   = lowest_idx(~armed_q);
	assign fire_idx   = lowest_idx(fired_q);
	assign fired_rest = fired_q & (fired_q - SLOTS'(1));

	// Shared deadline comparator, walked over the slots by idx_q.
	assign cmp_lt        = dl_mem[idx_q] < tick_q;
	assign fire_hit      = armed_q[idx_q] && cmp_lt;
	assign scan_end      = (idx_q == IDX_W'(SLOTS - 1));
	assign fired_any_nxt = (|fired_q) || fire_hit;

	// Window counters for the tick in progress.
	assign wt_inc   = win_ticks_q + WIN_W'(1);
	assign wb_inc   = win_busy_q + WIN_W'(!idle_q);
	assign win_full = (wt_inc >= WIN_W'(WINDOW_TICKS));

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = mode ? ST_REG : ST_TICK;
				end
			end
			ST_REG:  state_nxt = ST_IDLE;
			ST_TICK: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (scan_end) begin
					priority if (report_q) begin
						state_nxt = ST_REPORT;
					end else if (fired_any_nxt) begin
						state_nxt = ST_FIRE;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_REPORT: state_nxt = (|fired_q) ? ST_FIRE : ST_DONE;
			ST_FIRE:   state_nxt = (|fired_rest) ? ST_FIRE : ST_DONE;
			ST_DONE:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Result decode for the current state.
	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_DONE;
		emit_slot = '0;
		emit_acc  = 1'b0;
		emit_busy = '0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_REG: begin
				emit      = 1'b1;
				emit_kind = KIND_REPLY;
				emit_slot = free_found ? free_idx : '0;
				emit_acc  = free_found;
				emit_last = 1'b1;
			end
			ST_REPORT: begin
				emit      = 1'b1;
				emit_kind = KIND_REPORT;
				emit_busy = report_busy_q;
			end
			ST_FIRE: begin
				emit      = 1'b1;
				emit_kind = KIND_FIRE;
				emit_slot = fire_idx;
			end
			ST_DONE: begin
				emit      = 1'b1;
				emit_kind = KIND_DONE;
				emit_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			tick_q      <= '0;
			win_ticks_q <= '0;
			win_busy_q  <= '0;
			report_q    <= 1'b0;
			armed_q     <= '0;
			fired_q     <= '0;
			armed_cnt_q <= '0;
			strobe_q    <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			strobe_q <= emit;
			unique case (state_q)
				ST_REG: begin
					if (free_found) begin
						armed_q[free_idx] <= 1'b1;
						armed_cnt_q       <= armed_cnt_q + CNT_W'(1);
					end
				end
				ST_TICK: begin
					tick_q   <= tick_q + NOW_W'(1);
					idx_q    <= '0;
					fired_q  <= '0;
					report_q <= win_full;
					if (win_full) begin
						win_ticks_q <= '0;
						win_busy_q  <= '0;
					end else begin
						win_ticks_q <= wt_inc;
						win_busy_q  <= wb_inc;
					end
				end
				ST_SCAN: begin
					if (fire_hit) begin
						fired_q[idx_q] <= 1'b1;
						armed_q[idx_q] <= 1'b0;
						armed_cnt_q    <= armed_cnt_q - CNT_W'(1);
					end
					if (!scan_end) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_FIRE: begin
					fired_q <= fired_rest;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// Request capture, deadline store and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			dl_in_q <= deadline;
			idle_q  <= idle;
		end
		if (state_q == ST_REG && free_found) begin
			dl_mem[free_idx] <= dl_in_q;
		end
		if (state_q == ST_TICK) begin
			report_busy_q <= wb_inc;
		end
		kind_q <= emit_kind;
		slot_q <= emit_slot;
		acc_q  <= emit_acc;
		busy_q <= emit_busy;
		last_q <= emit_last;
	end

	// Output fields, masked to their port widths.
	assign slot_ext  = SEXT_W'(slot_q);
	assign busy_ext  = BEXT_W'(busy_q);
	assign armed_ext = AEXT_W'(armed_cnt_q);

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign slot        = slot_ext[SLOT_W-1:0];
	assign accepted    = acc_q;
	assign busy_ticks  = busy_ext[BUSY_W-1:0];
	assign now         = tick_q;
	assign armed_count = armed_ext[ARMED_W-1:0];
	assign last        = last_q;

	// The final result of an item always shows with the sequencer back at rest.
	`TAS_ASSERT_IMP(a_last_at_idle, strobe && last, state_q == ST_IDLE, "last result while busy")
	// The running armed count tracks the armed bits.
	`TAS_ASSERT_IMP(a_armed_cnt, 1'b1, armed_cnt_q == CNT_W'($countones(armed_q)), "armed count mismatch")
	// A slot marked as fired has already been freed.
	`TAS_ASSERT_IMP(a_fired_free, 1'b1, (fired_q & armed_q) == '0, "fired slot still armed")
	// An accepted request makes the block busy.
	`TAS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request left block idle")

endmodule

>>> tb/tick_alarm_slots_with_load_window_tb.sv
// ----------------------------------------------------------------------------
// tick_alarm_slots_with_load_window_tb
// Self-checking bench for the tick counter with its alarm table and busy window.
// Requests go in through the start/busy handshake. A behavioral model of the
// tick count, the busy window and the alarm slots predicts every result. A
// monitor compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tick_alarm_slots_with_load_window_tb
	import tas_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Request modes.
	localparam bit MODE_TICK     = 1'b0;
	localparam bit MODE_REGISTER = 1'b1;

	localparam int DRAIN_CYCLES = 3 * (TAS_SLOTS + 4);

	typedef struct {
		kind_t              kind;
		bit [SLOT_W-1:0]    slot;
		bit                 accepted;
		bit [BUSY_W-1:0]    busy_ticks;
		bit [NOW_W-1:0]     now;
		bit [ARMED_W-1:0]   armed_count;
		bit                 last;
	} alarm_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic [NOW_W-1:0]   deadline;
	logic               idle;
	logic               strobe;
	logic [KIND_W-1:0]  kind;
	logic [SLOT_W-1:0]  slot;
	logic               accepted;
	logic [BUSY_W-1:0]  busy_ticks;
	logic [NOW_W-1:0]   now;
	logic [ARMED_W-1:0] armed_count;
	logic               last;

	// Model state of the block.
	bit [NOW_W-1:0] tick_now;
	int             win_count;
	int             win_busy;
	bit             slot_armed_q [TAS_SLOTS];
	bit [NOW_W-1:0] slot_due [TAS_SLOTS];

	alarm_result_t expected_results [$];

	int gap_pct;
	int error_count;
	int ticks_sent;
	int registers_sent;
	int results_checked;
	int reports_seen;
	int fires_seen;
	int rejects_seen;

	tick_alarm_slots_with_load_window uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.deadline    (deadline),
		.idle        (idle),
		.strobe      (strobe),
		.kind        (kind),
		.slot        (slot),
		.accepted    (accepted),
		.busy_ticks  (busy_ticks),
		.now         (now),
		.armed_count (armed_count),
		.last        (last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on run time.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int armed_total();
		int n;
		n = 0;
		for (int i = 0; i < TAS_SLOTS; i++)
			if (slot_armed_q[i])
				n++;
		return n;
	endfunction

	function automatic alarm_result_t make_result(kind_t k, int s, bit acc, int bt, bit lst);
		alarm_result_t r;
		r.kind        = k;
		r.slot        = s[SLOT_W-1:0];
		r.accepted    = acc;
		r.busy_ticks  = bt[BUSY_W-1:0];
		r.now         = tick_now;
		r.armed_count = ARMED_W'(armed_total());
		r.last        = lst;
		return r;
	endfunction

	// Update the model with one accepted request and queue what it must produce.
	task automatic predict_alarm_results(input bit m, input bit [NOW_W-1:0] dl, input bit idl);
		int  free_slot;
		bit  report;
		int  busy_done;
		bit  fired [TAS_SLOTS];
		if (m == MODE_REGISTER) begin
			free_slot = -1;
			for (int i = 0; i < TAS_SLOTS; i++) begin
				if (!slot_armed_q[i] && free_slot < 0)
					free_slot = i;
			end
			if (free_slot >= 0) begin
				slot_armed_q[free_slot] = 1'b1;
				slot_due[free_slot]     = dl;
			end
			expected_results.push_back(make_result(KIND_REPLY,
				(free_slot >= 0) ? free_slot : 0, free_slot >= 0, 0, 1'b1));
			return;
		end
		// A tick: advance the count, then the window, then scan the slots.
		tick_now  = tick_now + 1;
		win_count = win_count + 1;
		if (!idl)
			win_busy = win_busy + 1;
		report    = 1'b0;
		busy_done = 0;
		if (win_count >= TAS_WINDOW_TICKS) begin
			report    = 1'b1;
			busy_done = win_busy;
			win_count = 0;
			win_busy  = 0;
		end
		for (int i = 0; i < TAS_SLOTS; i++) begin
			fired[i] = slot_armed_q[i] && (slot_due[i] < tick_now);
			if (fired[i])
				slot_armed_q[i] = 1'b0;
		end
		if (report)
			expected_results.push_back(make_result(KIND_REPORT, 0, 1'b0, busy_done, 1'b0));
		for (int i = 0; i < TAS_SLOTS; i++)
			if (fired[i])
				expected_results.push_back(make_result(KIND_FIRE, i, 1'b0, 0, 1'b0));
		expected_results.push_back(make_result(KIND_DONE, 0, 1'b0, 0, 1'b1));
	endtask

	// Send one request. Called at a clock edge; returns at the edge that accepts it.
	task automatic issue_request(input bit m, input bit [NOW_W-1:0] dl, input bit idl);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < gap_pct);
		end
		start    <= 1'b1;
		mode     <= m;
		deadline <= dl;
		idle     <= idl;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_alarm_results(m, dl, idl);
		if (m == MODE_REGISTER)
			registers_sent++;
		else
			ticks_sent++;
	endtask

	task automatic send_tick(input bit idl);
		issue_request(MODE_TICK, $urandom(), idl);
	endtask

	task automatic send_register(input bit [NOW_W-1:0] dl);
		issue_request(MODE_REGISTER, dl, 1'($urandom_range(0, 1)));
	endtask

	// Check each strobed result against the oldest prediction.
	always @(posedge clk) begin
		alarm_result_t exp_r;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d now %0d", kind, slot, now);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				results_checked++;
				if (exp_r.kind == KIND_REPORT)
					reports_seen++;
				if (exp_r.kind == KIND_FIRE)
					fires_seen++;
				if (exp_r.kind == KIND_REPLY && !exp_r.accepted)
					rejects_seen++;
				if (kind !== exp_r.kind) begin
					$error("kind: expected %0d, got %0d", exp_r.kind, kind);
					error_count++;
				end
				if (slot !== exp_r.slot) begin
					$error("slot: expected %0d, got %0d", exp_r.slot, slot);
					error_count++;
				end
				if (accepted !== exp_r.accepted) begin
					$error("accepted: expected %0d, got %0d", exp_r.accepted, accepted);
					error_count++;
				end
				if (busy_ticks !== exp_r.busy_ticks) begin
					$error("busy_ticks: expected %0d, got %0d", exp_r.busy_ticks, busy_ticks);
					error_count++;
				end
				if (now !== exp_r.now) begin
					$error("now: expected %0d, got %0d", exp_r.now, now);
					error_count++;
				end
				if (armed_count !== exp_r.armed_count) begin
					$error("armed_count: expected %0d, got %0d", exp_r.armed_count, armed_count);
					error_count++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, last);
					error_count++;
				end
			end
		end
	end

	// Registration order, full table, passed and equal deadlines, ignored fields.
	task automatic test_directed();
		gap_pct = 7;
		send_tick(1'b0);
		issue_request(MODE_TICK, '0, 1'b1);
		issue_request(MODE_REGISTER, '0, 1'b1);
		issue_request(MODE_REGISTER, 32'd2, 1'b0);
		send_register(32'd3);
		send_register(32'd1);
		send_register('1);
		send_register('0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_register(32'd4);
		send_register(32'd5);
		send_register(32'd6);
		send_register(32'd4);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_register(32'd7);
		send_tick(1'b1);
	endtask

	// One whole window with every tick busy, so the report carries the full
	// count. Before its last tick the whole table is armed with due deadlines
	// so that the report and every slot fire on the same tick.
	task automatic test_window_extremes();
		gap_pct = 0;
		while (win_count != 0)
			send_tick(1'($urandom_range(0, 1)));
		for (int t = 0; t < TAS_WINDOW_TICKS; t++) begin
			if (t == TAS_WINDOW_TICKS - 1) begin
				while (armed_total() < TAS_SLOTS)
					send_register(tick_now - $urandom_range(0, 2));
				send_register(tick_now);
			end
			send_tick(1'b0);
		end
	endtask

	// Mostly ticks, with registrations whose deadlines sit near the count.
	task automatic test_random(input int count);
		bit [NOW_W-1:0] dl;
		int             reg_pct;
		int             back;
		for (int n = 0; n < count; n++) begin
			case ((n * 3) / count)
				0: gap_pct = 7;
				1: gap_pct = 72;
				default: gap_pct = 0;
			endcase
			reg_pct = (armed_total() < TAS_SLOTS) ? 35 : 8;
			if ($urandom_range(0, 99) < reg_pct) begin
				if ($urandom_range(0, 3) == 0) begin
					back = (tick_now < 20) ? tick_now : 20;
					dl   = tick_now - $urandom_range(0, back);
				end else begin
					dl = tick_now + $urandom_range(0, 15);
				end
				send_register(dl);
			end else begin
				send_tick(1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Deadlines far ahead of the count stay armed for the rest of the run.
	task automatic test_far_deadlines();
		gap_pct = 72;
		while (armed_total() != 0)
			send_tick(1'($urandom_range(0, 1)));
		send_register('1);
		send_register(32'h8000_0000);
		send_register(32'h5555_5555);
		send_register($urandom() | 32'h8000_0000);
		send_register(32'hAAAA_AAAA);
		for (int i = 0; i < 3; i++)
			send_tick(1'($urandom_range(0, 1)));
	endtask

	// Reset, the tests in turn, drain and verdict.
	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		mode            = 1'b0;
		deadline        = '0;
		idle            = 1'b0;
		tick_now        = '0;
		win_count       = 0;
		win_busy        = 0;
		gap_pct         = 0;
		error_count     = 0;
		ticks_sent      = 0;
		registers_sent  = 0;
		results_checked = 0;
		reports_seen    = 0;
		fires_seen      = 0;
		rejects_seen    = 0;
		for (int i = 0; i < TAS_SLOTS; i++) begin
			slot_armed_q[i] = 1'b0;
			slot_due[i]     = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_extremes();
		test_directed();
		test_random(160);
		test_far_deadlines();

		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d ticks and %0d alarm registrations; checked %0d results.",
			ticks_sent, registers_sent, results_checked);
		$display("Seen %0d window reports, %0d alarm fires and %0d rejected registrations.",
			reports_seen, fires_seen, rejects_seen);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
